/* hw/rtl/fclf_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and types for the five channel linear fade block
// no dependencies
package fclf_pkg;

  localparam int CHANNELS          = 5;
  localparam int LEVEL_W           = 16;
  localparam int FADE_SPAN_DEFAULT = 500;
  localparam int ELAPSED_STEP      = 2;

  localparam logic [LEVEL_W-1:0] FLOOR_RESET = 16'd300;

  // channel slots
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_WARM  = 3;
  localparam int CH_COOL  = 4;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_STOP    = 2'd2;

  // register bus
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = ADDR_W - 2;

  localparam logic [INDEX_W-1:0] REG_FLOOR_RED   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_FLOOR_GREEN = 3'd1;
  localparam logic [INDEX_W-1:0] REG_FLOOR_BLUE  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_FLOOR_WARM  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_FLOOR_COOL  = 3'd4;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t [CHANNELS-1:0] levels_t;

  // per-word control that rides along the interpolation pipe
  typedef struct packed {
    logic first;
    logic cut;
    logic done;
  } issue_ctl_t;

endpackage

/* hw/rtl/five_channel_linear_fade.sv */
`timescale 1ns / 1ps
// five channel linear fade engine, top level
// depends on fclf_pkg, fclf_regs, fclf_ctrl, fclf_interp
//
// usage:
//   the item channel (item_valid / item_stall) takes one word per cycle
//   while item_stall is low: a tick, a restart carrying five target
//   levels, or a stop. restart and stop words and ticks that find the
//   fade idle update state only; an active tick produces one result word
//   on the result channel (result_valid / result_stall) with five dac
//   levels, green_enable and fade_done.
//   an accepted tick loads stage a on the accepting edge, then moves
//   through stages b, c and the output register. throughput: one word
//   per cycle while item_stall is low; the first tick after a restart
//   waits in the first stage until older ticks have written back the
//   current levels.
//   when the receiver stalls, the output register holds its word and the
//   pipe keeps filling; item_stall rises once the first stage cannot move.
//   floor registers sit at byte addresses 0, 4, 8, 12, 16; the user must
//   write them only while the block is idle, which the block does not enforce.
//   reset (rst, synchronous) clears the stored start, current and target
//   levels, elapsed time and the armed flag and sets every floor to 300.
module five_channel_linear_fade #(
  parameter int FADE_SPAN = fclf_pkg::FADE_SPAN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fclf_pkg::ADDR_W-1:0]  paddr,
  input  logic [fclf_pkg::DATA_W-1:0]  pwdata,
  output logic [fclf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   operation,
  input  logic [15:0]                  target_red,
  input  logic [15:0]                  target_green,
  input  logic [15:0]                  target_blue,
  input  logic [15:0]                  target_warm,
  input  logic [15:0]                  target_cool,
  input  logic                         lamp_connected,
  input  logic                         indoor_power_present,
  input  logic                         power_ratio_zero,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [15:0]                  level_red,
  output logic [15:0]                  level_green,
  output logic [15:0]                  level_blue,
  output logic [15:0]                  level_warm,
  output logic [15:0]                  level_cool,
  output logic                         green_enable,
  output logic                         fade_done
);

  localparam int TW = $clog2(FADE_SPAN + 1);

  fclf_pkg::levels_t    floors;
  fclf_pkg::levels_t    targets_in;
  fclf_pkg::levels_t    issue_targets;
  fclf_pkg::levels_t    result_levels;
  fclf_pkg::issue_ctl_t issue_ctl;
  logic [TW-1:0]        issue_elapsed;
  logic                 issue;
  logic                 accept;
  logic                 busy;

  assign targets_in[fclf_pkg::CH_RED]   = target_red;
  assign targets_in[fclf_pkg::CH_GREEN] = target_green;
  assign targets_in[fclf_pkg::CH_BLUE]  = target_blue;
  assign targets_in[fclf_pkg::CH_WARM]  = target_warm;
  assign targets_in[fclf_pkg::CH_COOL]  = target_cool;

  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;

  assign level_red   = result_levels[fclf_pkg::CH_RED];
  assign level_green = result_levels[fclf_pkg::CH_GREEN];
  assign level_blue  = result_levels[fclf_pkg::CH_BLUE];
  assign level_warm  = result_levels[fclf_pkg::CH_WARM];
  assign level_cool  = result_levels[fclf_pkg::CH_COOL];

  fclf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .floors  (floors)
  );

  fclf_ctrl #(
    .FADE_SPAN (FADE_SPAN)
  ) u_ctrl (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (accept),
    .operation            (operation),
    .targets_in           (targets_in),
    .lamp_connected       (lamp_connected),
    .indoor_power_present (indoor_power_present),
    .power_ratio_zero     (power_ratio_zero),
    .issue                (issue),
    .issue_ctl            (issue_ctl),
    .issue_elapsed        (issue_elapsed),
    .issue_targets        (issue_targets)
  );

  fclf_interp #(
    .FADE_SPAN (FADE_SPAN)
  ) u_interp (
    .clk           (clk),
    .rst           (rst),
    .load          (accept && issue),
    .issue_ctl     (issue_ctl),
    .issue_elapsed (issue_elapsed),
    .issue_targets (issue_targets),
    .floors        (floors),
    .busy          (busy),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_levels (result_levels),
    .green_enable  (green_enable),
    .fade_done     (fade_done)
  );

endmodule

/* hw/rtl/fclf_regs.sv */
`timescale 1ns / 1ps
// floor registers behind the apb-style configuration port
// depends on fclf_pkg
module fclf_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fclf_pkg::ADDR_W-1:0]  paddr,
  input  logic [fclf_pkg::DATA_W-1:0]  pwdata,
  output logic [fclf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output fclf_pkg::levels_t            floors
);

  logic [fclf_pkg::INDEX_W-1:0] index;
  logic                         wr;

  assign index  = paddr[fclf_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fclf_pkg::CHANNELS; i++) begin
        floors[i] <= fclf_pkg::FLOOR_RESET;
      end
    end else if (wr) begin
      unique case (index)
        fclf_pkg::REG_FLOOR_RED:   floors[fclf_pkg::CH_RED]   <= pwdata[fclf_pkg::LEVEL_W-1:0];
        fclf_pkg::REG_FLOOR_GREEN: floors[fclf_pkg::CH_GREEN] <= pwdata[fclf_pkg::LEVEL_W-1:0];
        fclf_pkg::REG_FLOOR_BLUE:  floors[fclf_pkg::CH_BLUE]  <= pwdata[fclf_pkg::LEVEL_W-1:0];
        fclf_pkg::REG_FLOOR_WARM:  floors[fclf_pkg::CH_WARM]  <= pwdata[fclf_pkg::LEVEL_W-1:0];
        fclf_pkg::REG_FLOOR_COOL:  floors[fclf_pkg::CH_COOL]  <= pwdata[fclf_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      fclf_pkg::REG_FLOOR_RED:   prdata[fclf_pkg::LEVEL_W-1:0] = floors[fclf_pkg::CH_RED];
      fclf_pkg::REG_FLOOR_GREEN: prdata[fclf_pkg::LEVEL_W-1:0] = floors[fclf_pkg::CH_GREEN];
      fclf_pkg::REG_FLOOR_BLUE:  prdata[fclf_pkg::LEVEL_W-1:0] = floors[fclf_pkg::CH_BLUE];
      fclf_pkg::REG_FLOOR_WARM:  prdata[fclf_pkg::LEVEL_W-1:0] = floors[fclf_pkg::CH_WARM];
      fclf_pkg::REG_FLOOR_COOL:  prdata[fclf_pkg::LEVEL_W-1:0] = floors[fclf_pkg::CH_COOL];
      default: prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/fclf_ctrl.sv */
`timescale 1ns / 1ps
// fade sequencing: arm/disarm, elapsed counter, target store, tick issue
// depends on fclf_pkg
module fclf_ctrl #(
  parameter int FADE_SPAN = fclf_pkg::FADE_SPAN_DEFAULT,
  localparam int TW = $clog2(FADE_SPAN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [1:0]             operation,
  input  fclf_pkg::levels_t      targets_in,
  input  logic                   lamp_connected,
  input  logic                   indoor_power_present,
  input  logic                   power_ratio_zero,
  output logic                   issue,
  output fclf_pkg::issue_ctl_t   issue_ctl,
  output logic [TW-1:0]          issue_elapsed,
  output fclf_pkg::levels_t      issue_targets
);

  localparam logic [TW-1:0] SPAN = TW'(FADE_SPAN);

  logic [TW-1:0]     elapsed;
  logic              armed;
  fclf_pkg::levels_t target_levels;

  logic [TW:0]       bumped;
  logic [TW-1:0]     elapsed_next;
  logic              run;

  assign bumped       = {1'b0, elapsed} + (TW+1)'(fclf_pkg::ELAPSED_STEP);
  // saturate the last step when the span is odd
  assign elapsed_next = (bumped > {1'b0, SPAN}) ? SPAN : bumped[TW-1:0];
  assign run          = armed && lamp_connected && (elapsed < SPAN);

  assign issue           = (operation == fclf_pkg::OP_TICK) && run;
  assign issue_ctl.first = (elapsed == '0);
  assign issue_ctl.cut   = indoor_power_present && power_ratio_zero;
  assign issue_ctl.done  = (elapsed_next == SPAN);
  assign issue_elapsed   = elapsed_next;
  assign issue_targets   = target_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= '0;
      armed         <= 1'b0;
      target_levels <= '0;
    end else if (accept) begin
      unique case (operation)
        fclf_pkg::OP_RESTART: begin
          target_levels <= targets_in;
          elapsed       <= '0;
          armed         <= 1'b1;
        end
        fclf_pkg::OP_STOP: begin
          armed <= 1'b0;
        end
        fclf_pkg::OP_TICK: begin
          if (run) begin
            elapsed <= elapsed_next;
          end
        end
        default: ;
      endcase
    end
  end

  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    elapsed <= SPAN)
    else $error("elapsed ran past the fade span");

  a_elapsed_follows: assert property (@(posedge clk) disable iff (rst)
    accept && issue |=> elapsed == $past(issue_elapsed))
    else $error("elapsed did not take the issued value");

  a_issue_nonzero: assert property (@(posedge clk) disable iff (rst)
    issue |-> issue_elapsed != '0)
    else $error("tick issued with zero elapsed");

endmodule

/* hw/rtl/fclf_interp.sv */
`timescale 1ns / 1ps
// three-stage interpolation pipe with output register and level state
// depends on fclf_pkg
module fclf_interp #(
  parameter int FADE_SPAN = fclf_pkg::FADE_SPAN_DEFAULT,
  localparam int TW = $clog2(FADE_SPAN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  fclf_pkg::issue_ctl_t   issue_ctl,
  input  logic [TW-1:0]          issue_elapsed,
  input  fclf_pkg::levels_t      issue_targets,
  input  fclf_pkg::levels_t      floors,
  output logic                   busy,
  output logic                   result_valid,
  input  logic                   result_stall,
  output fclf_pkg::levels_t      result_levels,
  output logic                   green_enable,
  output logic                   fade_done
);

  localparam int LW     = fclf_pkg::LEVEL_W;
  localparam int CL     = $clog2(FADE_SPAN);
  localparam int YW     = LW + CL;            // rounded numerator width
  localparam int K      = YW + CL;            // reciprocal shift
  localparam int MW     = YW + 1;             // reciprocal width
  localparam int LOW_W  = (YW + 1) / 2;
  localparam int HIGH_W = YW - LOW_W;
  localparam int PLW    = LOW_W + MW;
  localparam int PHW    = HIGH_W + MW;
  localparam int SUMW   = YW + MW;
  localparam int MULW   = LW + TW;

  localparam logic [63:0]     POW_K = 64'd1 << K;
  localparam logic [MW-1:0]   RECIP = MW'((POW_K + 64'(FADE_SPAN) - 64'd1) / 64'(FADE_SPAN));
  localparam logic [YW-1:0]   HALF  = YW'(FADE_SPAN / 2);
  localparam logic [TW-1:0]   SPAN  = TW'(FADE_SPAN);

  fclf_pkg::levels_t    start_levels;
  fclf_pkg::levels_t    current_levels;

  // stage a
  logic                 a_valid, a_valid_next;
  fclf_pkg::issue_ctl_t a_ctl;
  logic [TW-1:0]        a_t;
  fclf_pkg::levels_t    a_tgt;
  // stage b
  logic                 b_valid, b_valid_next;
  fclf_pkg::issue_ctl_t b_ctl;
  logic [YW-1:0]        b_y [fclf_pkg::CHANNELS];
  // stage c
  logic                 c_valid, c_valid_next;
  fclf_pkg::issue_ctl_t c_ctl;
  logic [PHW-1:0]       c_ph [fclf_pkg::CHANNELS];
  logic [PLW-1:0]       c_pl [fclf_pkg::CHANNELS];
  logic                 result_valid_next;

  logic                 out_free, c_free, b_free, a_free;
  logic                 c_move, b_move, a_move, hazard;

  fclf_pkg::levels_t    s_sel;
  logic [TW-1:0]        rem_t;
  logic [MULW-1:0]      m_start [fclf_pkg::CHANNELS];
  logic [MULW-1:0]      m_tgt [fclf_pkg::CHANNELS];
  logic [YW-1:0]        y [fclf_pkg::CHANNELS];
  logic [PHW-1:0]       ph [fclf_pkg::CHANNELS];
  logic [PLW-1:0]       pl [fclf_pkg::CHANNELS];
  logic [SUMW-1:0]      total [fclf_pkg::CHANNELS];
  fclf_pkg::levels_t    q;
  fclf_pkg::levels_t    q_out;
  logic                 green_c;

  // a first tick snapshots current levels, so it waits until older ticks have left
  assign hazard   = a_ctl.first && (b_valid || c_valid);
  assign out_free = !result_valid || !result_stall;
  assign c_move   = c_valid && out_free;
  assign c_free   = !c_valid || out_free;
  assign b_move   = b_valid && c_free;
  assign b_free   = !b_valid || c_free;
  assign a_move   = a_valid && b_free && !hazard;
  assign a_free   = !a_valid || (b_free && !hazard);
  assign busy     = !a_free;

  assign a_valid_next      = load || (a_valid && !a_move);
  assign b_valid_next      = a_move || (b_valid && !b_move);
  assign c_valid_next      = b_move || (c_valid && !c_move);
  assign result_valid_next = c_move || (result_valid && result_stall);

  // stage a: start select and weighted sum
  assign rem_t = SPAN - a_t;

  always_comb begin
    for (int i = 0; i < fclf_pkg::CHANNELS; i++) begin
      if (a_ctl.first) begin
        // dark channel with a lit target starts from its floor
        s_sel[i] = (current_levels[i] == '0 && a_tgt[i] != '0) ? floors[i]
                                                               : current_levels[i];
      end else begin
        s_sel[i] = start_levels[i];
      end
      m_start[i] = {{TW{1'b0}}, s_sel[i]} * {{LW{1'b0}}, rem_t};
      m_tgt[i]   = {{TW{1'b0}}, a_tgt[i]} * {{LW{1'b0}}, a_t};
      y[i]       = YW'(m_start[i]) + YW'(m_tgt[i]) + HALF;
    end
  end

  // stage b: partial products against the reciprocal of the span
  always_comb begin
    for (int i = 0; i < fclf_pkg::CHANNELS; i++) begin
      ph[i] = PHW'(b_y[i][YW-1:LOW_W]) * PHW'(RECIP);
      pl[i] = PLW'(b_y[i][LOW_W-1:0]) * PLW'(RECIP);
    end
  end

  // stage c: recombine, take the quotient, apply power cut
  always_comb begin
    for (int i = 0; i < fclf_pkg::CHANNELS; i++) begin
      total[i] = (SUMW'(c_ph[i]) << LOW_W) + SUMW'(c_pl[i]);
      q[i]     = total[i][K +: LW];
      q_out[i] = c_ctl.cut ? '0 : q[i];
    end
    green_c = (q[fclf_pkg::CH_GREEN] != '0) &&
              (q[fclf_pkg::CH_GREEN] >= floors[fclf_pkg::CH_GREEN]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
      c_valid        <= 1'b0;
      result_valid   <= 1'b0;
      start_levels   <= '0;
      current_levels <= '0;
    end else begin
      a_valid      <= a_valid_next;
      b_valid      <= b_valid_next;
      c_valid      <= c_valid_next;
      result_valid <= result_valid_next;
      if (a_move && a_ctl.first) begin
        start_levels <= s_sel;
      end
      if (c_move) begin
        current_levels <= q_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_ctl <= issue_ctl;
      a_t   <= issue_elapsed;
      a_tgt <= issue_targets;
    end
    if (a_move) begin
      b_ctl <= a_ctl;
      for (int i = 0; i < fclf_pkg::CHANNELS; i++) begin
        b_y[i] <= y[i];
      end
    end
    if (b_move) begin
      c_ctl <= b_ctl;
      for (int i = 0; i < fclf_pkg::CHANNELS; i++) begin
        c_ph[i] <= ph[i];
        c_pl[i] <= pl[i];
      end
    end
    if (c_move) begin
      result_levels <= q_out;
      green_enable  <= green_c;
      fade_done     <= c_ctl.done;
    end
  end

  a_first_alone: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_ctl.first |-> !c_valid)
    else $error("first tick overtook an older tick");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(c_valid))
    else $error("result appeared without a word in the last stage");

  a_stage_a_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_move |=> a_valid)
    else $error("word lost from the first stage");

endmodule
